// ----- rtl/text_whitespace_normalizer_defines.svh -----
// assertion macros for the whitespace normaliser
`ifndef TEXT_WHITESPACE_NORMALIZER_DEFINES_SVH
`define TEXT_WHITESPACE_NORMALIZER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TWN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/twn_pkg.sv -----
// shared types, character codes and helpers of the whitespace normaliser
`default_nettype none

package twn_pkg;

    localparam int HELD_DEPTH_DEF = 32;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       text_done;
        logic       step_last;
        logic       held_overflow;
    } t_out;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic closes_space(input logic [7:0] b);
        return (b == CH_COMMA) || (b == CH_DOT) || (b == CH_BANG) || (b == CH_QUEST) ||
               (b == CH_SEMI) || (b == CH_COLON) || (b == CH_NL);
    endfunction

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= CH_LO_A) && (b <= CH_LO_Z);
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= CH_UP_A) && (b <= CH_UP_Z);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/text_whitespace_normalizer.sv -----
// whitespace normaliser top level: run collapse, held whitespace store and capitalisation
//
// usage
// - input channel i_in / i_in_valid / o_in_ready carries one text byte per request,
//   with text_end set on the final byte of a text
// - output channel o_out / o_out_valid / i_out_ready carries result requests; every
//   input request whose results are all sent ends with step_last, the final one of a
//   text also with text_done (a bare end marker has has_byte low)
// - a space or tab is only recorded; other whitespace is written to the held store,
//   after the collapsed space when one is kept; a text end on it adds the state S_END
// - a visible byte is accepted, then each held byte is replayed from the store through
//   S_FLUSH_RD and S_FLUSH_WR (one read port, registered read data), and the byte
//   itself goes out last from S_EMIT
// - o_in_ready is high only while the sequencer is idle; a result left waiting in the
//   output register does not hold off the next request
// - a stalled receiver freezes the sequencer at its next push; nothing is lost
// - synchronous active-low reset clears flags, held count and output valid; the
//   held store itself needs no clearing since only entries below the count are read
// - the state returns to reset values after the last result of each text
`default_nettype none

`include "text_whitespace_normalizer_defines.svh"

module text_whitespace_normalizer #(
    parameter int HELD_DEPTH = twn_pkg::HELD_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire twn_pkg::t_in i_in,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output twn_pkg::t_out     o_out,
    output logic              o_out_valid,
    input  wire logic         i_out_ready
);

    localparam int CW = $clog2(HELD_DEPTH + 1);
    localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HELD_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_HOLD     = 6'b000010,
        S_FLUSH_RD = 6'b000100,
        S_FLUSH_WR = 6'b001000,
        S_EMIT     = 6'b010000,
        S_END      = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // text tracking flags
    logic r_pending, n_pending;
    logic r_nothing, n_nothing;
    logic r_last_nl, n_last_nl;
    logic r_cap,     n_cap;
    logic r_ovf,     n_ovf;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;

    // latched request payload (case already applied)
    logic [7:0] r_c, n_c;
    logic       r_end, n_end;

    // output register
    twn_pkg::t_out r_out;
    logic          r_ovalid, n_ovalid;

    // held whitespace store
    logic [7:0] mem [HELD_DEPTH];
    logic [7:0] r_rdata;

    logic          in_acc;
    logic          can_push;
    logic          push;
    twn_pkg::t_out push_data;
    logic          hold_req;
    logic [7:0]    hold_byte;
    logic          rd_en;
    logic          we;
    logic          room;

    // decode of the incoming byte
    logic [7:0] c_in;
    logic       c_is_st;
    logic       c_ws;
    logic       sp_keep;
    logic [7:0] c_cased;
    logic       c_cap;

    assign in_acc   = i_in_valid && o_in_ready;
    assign can_push = !r_ovalid || i_out_ready;
    assign room     = (r_count < DEPTH_C);
    assign we       = hold_req && room;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out       = r_out;
    assign o_out_valid = r_ovalid;

    always_comb begin
        c_in    = i_in.in_byte;
        c_is_st = (c_in == twn_pkg::CH_SPACE) || (c_in == twn_pkg::CH_TAB);
        c_ws    = twn_pkg::is_ws(c_in) && !c_is_st;
        // collapsed space survives only mid-line and not before closing punctuation
        sp_keep = !c_is_st && r_pending && !(r_nothing || r_last_nl) &&
                  !twn_pkg::closes_space(c_in);
        c_cased = c_in;
        c_cap   = r_cap;
        if (twn_pkg::is_lower(c_in) || twn_pkg::is_upper(c_in)) begin
            if (r_cap && twn_pkg::is_lower(c_in)) begin
                c_cased = c_in - twn_pkg::CASE_OFFSET;
            end
            c_cap = 1'b0;
        end else if ((c_in == twn_pkg::CH_DOT) || (c_in == twn_pkg::CH_BANG) ||
                     (c_in == twn_pkg::CH_QUEST) || (c_in == twn_pkg::CH_NL)) begin
            c_cap = 1'b1;
        end else if (!twn_pkg::is_ws(c_in) && (c_in != twn_pkg::CH_DQUOTE) &&
                     (c_in != twn_pkg::CH_SQUOTE)) begin
            c_cap = 1'b0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_nothing = r_nothing;
        n_last_nl = r_last_nl;
        n_cap     = r_cap;
        n_ovf     = r_ovf;
        n_count   = r_count;
        n_idx     = r_idx;
        n_c       = r_c;
        n_end     = r_end;
        push      = 1'b0;
        push_data = '0;
        hold_req  = 1'b0;
        hold_byte = r_c;
        rd_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_c   = c_cased;
                    n_end = i_in.text_end;
                    n_idx = '0;
                    if (c_is_st) begin
                        n_pending = 1'b1;
                    end else begin
                        n_pending = 1'b0;
                        n_nothing = 1'b0;
                        n_last_nl = (c_in == twn_pkg::CH_NL);
                        n_cap     = c_cap;
                    end
                    // first store write: the kept space, else held whitespace itself
                    if (sp_keep || c_ws) begin
                        hold_req  = 1'b1;
                        hold_byte = sp_keep ? twn_pkg::CH_SPACE : c_in;
                    end
                    if (c_is_st || (c_ws && !sp_keep)) begin
                        n_state = i_in.text_end ? S_END : S_IDLE;
                    end else if (c_ws) begin
                        n_state = S_HOLD;
                    end else if ((r_count != '0) || sp_keep) begin
                        n_state = S_FLUSH_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_HOLD: begin
                hold_req  = 1'b1;
                hold_byte = r_c;
                n_state   = r_end ? S_END : S_IDLE;
            end
            S_FLUSH_RD: begin
                rd_en   = 1'b1;
                n_state = S_FLUSH_WR;
            end
            S_FLUSH_WR: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_data = '{out_byte: r_rdata, has_byte: 1'b1, text_done: 1'b0,
                                  step_last: 1'b0, held_overflow: 1'b0};
                    n_idx     = r_idx + ONE_C;
                    n_state   = ((r_idx + ONE_C) == r_count) ? S_EMIT : S_FLUSH_RD;
                end
            end
            S_EMIT: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_data = '{out_byte: r_c, has_byte: 1'b1, text_done: r_end,
                                  step_last: 1'b1, held_overflow: r_end && r_ovf};
                    n_count   = '0;
                    n_state   = S_IDLE;
                end
            end
            S_END: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_data = '{out_byte: 8'h00, has_byte: 1'b0, text_done: 1'b1,
                                  step_last: 1'b1, held_overflow: r_ovf};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // store full: byte dropped, sticky flag set
        if (hold_req) begin
            if (room) begin
                n_count = r_count + ONE_C;
            end else begin
                n_ovf = 1'b1;
            end
        end

        // end of text: back to reset values
        if (push && push_data.text_done) begin
            n_pending = 1'b0;
            n_nothing = 1'b1;
            n_last_nl = 1'b0;
            n_cap     = 1'b1;
            n_ovf     = 1'b0;
            n_count   = '0;
        end

        n_ovalid = push ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_nothing <= 1'b1;
            r_last_nl <= 1'b0;
            r_cap     <= 1'b1;
            r_ovf     <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_nothing <= n_nothing;
            r_last_nl <= n_last_nl;
            r_cap     <= n_cap;
            r_ovf     <= n_ovf;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_ovalid  <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_end <= n_end;
        if (push) begin
            r_out <= push_data;
        end
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_count[AW-1:0]] <= hold_byte;
        end
    end

    // store read port, registered read data
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    `TWN_ASSERT_IMP(a_count_bound, 1'b1, r_count <= DEPTH_C, "held count beyond store depth")
    `TWN_ASSERT_IMP(a_flush_index, (r_state == S_FLUSH_RD) || (r_state == S_FLUSH_WR), r_idx < r_count, "replay index past held count")
    `TWN_ASSERT_NXT(a_done_clears, push && push_data.text_done, (r_count == '0) && !r_ovf && r_nothing && r_cap, "state not cleared after end of text")
    `TWN_ASSERT_IMP(a_ovf_on_done, o_out_valid && o_out.held_overflow, o_out.text_done && o_out.step_last, "overflow flag away from end of text")

endmodule

`default_nettype wire
